### rtl/ttrb_pkg.sv
// Shared types and constants for the tick-tagged ring buffer.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package ttrb_pkg;

  localparam int unsigned DefDepth     = 64;
  localparam int unsigned DefPayloadW  = 32;
  localparam int unsigned TickW        = 32;
  localparam int unsigned PayloadPortW = 32;
  localparam int unsigned CountPortW   = 7;
  localparam int unsigned PayloadExtW  = 64;

  typedef enum logic [1:0] {
    OpRecord  = 2'd0,
    OpLookup  = 2'd1,
    OpDiscard = 2'd2,
    OpClear   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish
  } state_e;

endpackage

### rtl/ttrb_in_if.sv
// Input channel of the tick-tagged ring buffer: valid/ready plus command word.
// Depends on ttrb_pkg for field widths.
`timescale 1ns / 1ps

interface ttrb_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          operation;
  logic [ttrb_pkg::TickW-1:0]          tick;
  logic [ttrb_pkg::PayloadPortW-1:0]   payload;

  modport source (output valid, operation, tick, payload, input ready);
  modport sink   (input valid, operation, tick, payload, output ready);
endinterface

### rtl/ttrb_out_if.sv
// Result channel of the tick-tagged ring buffer: valid/ready plus result word.
// Depends on ttrb_pkg for field widths.
`timescale 1ns / 1ps

interface ttrb_out_if;
  logic                                valid;
  logic                                ready;
  logic                                found;
  logic [ttrb_pkg::PayloadPortW-1:0]   payload_out;
  logic [ttrb_pkg::CountPortW-1:0]     held_count;

  modport source (output valid, found, payload_out, held_count, input ready);
  modport sink   (input valid, found, payload_out, held_count, output ready);
endinterface

### rtl/tick_tagged_ring_buffer_top.sv
// Tick-tagged ring buffer: entry memory, pointers and scan sequencer.
// Depends on ttrb_pkg, ttrb_in_if and ttrb_out_if.
//
// Usage:
//   in_i carries one command word per handshake: record, lookup, discard or
//   clear, with a tick and a payload. out_o returns exactly one result word
//   per command: found flag, matching payload and the held count after it.
//   Record and clear go straight to the finish step, which loads the result.
//   Lookup and discard walk the held entries through one registered memory
//   read port, one entry per cycle. Lookup stops at the newest match,
//   discard at the first entry that is not older than the given tick.
//   in_i.ready is high only while the sequencer is idle; one command is in
//   work at a time. The sequencer returns to idle as the result register
//   is loaded.
//   The result register lets a new command be accepted while the previous
//   result still waits; a stalled out_o holds the word and the next command
//   waits in its finish step until the register frees.
//   Reset empties the ring (pointer and count to zero) and drops any result;
//   the entry memory itself is not cleared and needs no sweep.
`timescale 1ns / 1ps

module tick_tagged_ring_buffer_top #(
  parameter int unsigned BUFFER_DEPTH  = ttrb_pkg::DefDepth,
  parameter int unsigned PAYLOAD_WIDTH = ttrb_pkg::DefPayloadW
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ttrb_in_if.sink     in_i,
  ttrb_out_if.source  out_o
);

  localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned MW = ttrb_pkg::TickW + PAYLOAD_WIDTH;
  localparam logic [AW-1:0] LastIdx = AW'(BUFFER_DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(BUFFER_DEPTH);
  localparam logic [SW-1:0] DepthS  = SW'(BUFFER_DEPTH);

  ttrb_pkg::state_e state_q, state_d;
  ttrb_pkg::op_e    op_q, op_d;
  logic [ttrb_pkg::TickW-1:0]        key_q, key_d;
  logic [AW-1:0]                     ptr_q, ptr_d;
  logic [CW-1:0]                     left_q, left_d;
  logic                              pend_q, pend_d;
  logic [AW-1:0]                     wp_q, wp_d;
  logic [CW-1:0]                     count_q, count_d;
  logic                              res_found_q, res_found_d;
  logic [ttrb_pkg::PayloadPortW-1:0] res_pay_q, res_pay_d;
  logic                              ov_q, ov_d;
  logic                              of_q, of_d;
  logic [ttrb_pkg::PayloadPortW-1:0] op_pay_q, op_pay_d;
  logic [ttrb_pkg::CountPortW-1:0]   oc_q, oc_d;

  logic [MW-1:0] mem_q [BUFFER_DEPTH];
  logic [MW-1:0] rd_q;
  logic          mem_we;
  logic [MW-1:0] mem_wdata;

  logic                              accept;
  ttrb_pkg::op_e                     in_op;
  logic [ttrb_pkg::PayloadExtW-1:0]  in_pay_ext;
  logic [ttrb_pkg::PayloadExtW-1:0]  rd_pay_ext;
  logic [ttrb_pkg::TickW-1:0]        rd_tick;
  logic                              hit;
  logic                              out_free;
  logic                              scan_done;
  logic                              issue;
  logic [AW-1:0]                     newest;
  logic [AW-1:0]                     oldest;
  logic [SW-1:0]                     wp_s, cnt_s, old_s;
  logic [31:0]                       cnt_ext;

  assign in_i.ready = (state_q == ttrb_pkg::StIdle);
  assign accept     = in_i.valid && in_i.ready;
  assign in_op      = ttrb_pkg::op_e'(in_i.operation);
  assign in_pay_ext = ttrb_pkg::PayloadExtW'(in_i.payload);
  assign out_free   = !ov_q || out_o.ready;

  assign rd_tick = rd_q[PAYLOAD_WIDTH +: ttrb_pkg::TickW];
  always_comb begin
    rd_pay_ext = '0;
    rd_pay_ext[PAYLOAD_WIDTH-1:0] = rd_q[PAYLOAD_WIDTH-1:0];
  end

  assign newest = (wp_q == '0) ? LastIdx : wp_q - 1'b1;
  assign wp_s   = SW'(wp_q);
  assign cnt_s  = SW'(count_q);
  assign old_s  = (wp_s >= cnt_s) ? (wp_s - cnt_s) : (wp_s + DepthS - cnt_s);
  assign oldest = old_s[AW-1:0];

  assign hit = (op_q == ttrb_pkg::OpLookup) ? (rd_tick == key_q) : (rd_tick < key_q);
  assign scan_done = (pend_q && (op_q == ttrb_pkg::OpLookup) && hit)
                  || (pend_q && (op_q != ttrb_pkg::OpLookup) && !hit)
                  || (!pend_q && (left_q == '0));
  assign issue = (state_q == ttrb_pkg::StScan) && !scan_done && (left_q != '0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ttrb_pkg::StIdle: begin
        if (accept) begin
          if (in_op == ttrb_pkg::OpLookup || in_op == ttrb_pkg::OpDiscard) begin
            state_d = ttrb_pkg::StScan;
          end else begin
            state_d = ttrb_pkg::StFinish;
          end
        end
      end
      ttrb_pkg::StScan: begin
        if (scan_done) state_d = ttrb_pkg::StFinish;
      end
      ttrb_pkg::StFinish: begin
        if (out_free) state_d = ttrb_pkg::StIdle;
      end
      default: state_d = ttrb_pkg::StIdle;
    endcase
  end

  // datapath and outputs
  always_comb begin
    op_d        = op_q;
    key_d       = key_q;
    ptr_d       = ptr_q;
    left_d      = left_q;
    pend_d      = 1'b0;
    wp_d        = wp_q;
    count_d     = count_q;
    res_found_d = res_found_q;
    res_pay_d   = res_pay_q;
    ov_d        = ov_q && !out_o.ready;
    of_d        = of_q;
    op_pay_d    = op_pay_q;
    oc_d        = oc_q;
    mem_we      = 1'b0;
    mem_wdata   = {in_i.tick, in_pay_ext[PAYLOAD_WIDTH-1:0]};
    cnt_ext     = 32'(count_q);
    unique case (state_q)
      ttrb_pkg::StIdle: begin
        if (accept) begin
          op_d        = in_op;
          key_d       = in_i.tick;
          left_d      = count_q;
          res_found_d = 1'b0;
          res_pay_d   = '0;
          ptr_d       = (in_op == ttrb_pkg::OpLookup) ? newest : oldest;
          case (in_op)
            ttrb_pkg::OpRecord: begin
              mem_we = 1'b1;
              wp_d   = (wp_q == LastIdx) ? '0 : wp_q + 1'b1;
              if (count_q != FullCnt) count_d = count_q + 1'b1;
            end
            ttrb_pkg::OpClear: begin
              wp_d    = '0;
              count_d = '0;
            end
            default: ;
          endcase
        end
      end
      ttrb_pkg::StScan: begin
        if (pend_q && hit) begin
          if (op_q == ttrb_pkg::OpLookup) begin
            res_found_d = 1'b1;
            res_pay_d   = rd_pay_ext[ttrb_pkg::PayloadPortW-1:0];
          end else begin
            count_d = count_q - 1'b1;
          end
        end
        if (issue) begin
          pend_d = 1'b1;
          left_d = left_q - 1'b1;
          if (op_q == ttrb_pkg::OpLookup) begin
            ptr_d = (ptr_q == '0) ? LastIdx : ptr_q - 1'b1;
          end else begin
            ptr_d = (ptr_q == LastIdx) ? '0 : ptr_q + 1'b1;
          end
        end
      end
      ttrb_pkg::StFinish: begin
        if (out_free) begin
          ov_d     = 1'b1;
          of_d     = res_found_q;
          op_pay_d = res_pay_q;
          oc_d     = cnt_ext[ttrb_pkg::CountPortW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ttrb_pkg::StIdle;
      pend_q  <= 1'b0;
      wp_q    <= '0;
      count_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      wp_q    <= wp_d;
      count_q <= count_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    key_q       <= key_d;
    ptr_q       <= ptr_d;
    left_q      <= left_d;
    res_found_q <= res_found_d;
    res_pay_q   <= res_pay_d;
    of_q        <= of_d;
    op_pay_q    <= op_pay_d;
    oc_q        <= oc_d;
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[wp_q] <= mem_wdata;
    rd_q <= mem_q[ptr_q];
  end

  assign out_o.valid       = ov_q;
  assign out_o.found       = of_q;
  assign out_o.payload_out = op_pay_q;
  assign out_o.held_count  = oc_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("held count above depth");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_i.ready)
    else $error("ready high right after accept");

  a_pend_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> state_q == ttrb_pkg::StScan)
    else $error("read in flight outside scan");

  a_found_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.found) |-> out_o.held_count != '0)
    else $error("match reported on empty ring");

endmodule

### tb/tb_top.sv
// Self-checking testbench for tick_tagged_ring_buffer_top: record, lookup, discard, clear.
// Uses ttrb_pkg, ttrb_in_if and ttrb_out_if; every result is checked by predictor or typed row.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned Depth         = ttrb_pkg::DefDepth;
  localparam int unsigned PtrW          = $clog2(Depth);
  localparam int unsigned CntW          = ttrb_pkg::CountPortW;
  localparam int unsigned RandWords     = 1200;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned TailCycles    = Depth + 16;
  localparam int unsigned WatchdogLimit = 3000;

  typedef struct packed {
    logic                              found;
    logic [ttrb_pkg::PayloadPortW-1:0] payload_out;
    logic [CntW-1:0]                   held_count;
  } ring_result_t;

  typedef struct {
    ttrb_pkg::op_e                     op;
    logic [ttrb_pkg::TickW-1:0]        tick;
    logic [ttrb_pkg::PayloadPortW-1:0] pay;
    bit                                typed;
    ring_result_t                      res;
  } stim_row_t;

  logic clk;
  logic rst_n = 1'b0;

  ttrb_in_if  in_if ();
  ttrb_out_if out_if ();

  tick_tagged_ring_buffer_top i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // predicted ring contents
  logic [ttrb_pkg::TickW-1:0]        ring_tick [Depth];
  logic [ttrb_pkg::PayloadPortW-1:0] ring_pay  [Depth];
  logic [PtrW-1:0]                   wr_ptr = '0;
  logic [CntW-1:0]                   held   = '0;

  ring_result_t pending_results[$];
  stim_row_t    directed_rows[$];
  ring_result_t exp_word;
  int unsigned  mismatch_cnt = 0;
  int unsigned  words_sent   = 0;
  int unsigned  results_seen = 0;
  int unsigned  burst_left   = 0;
  int unsigned  idle_cycles  = 0;
  bit           offering     = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic ring_result_t predict_ring_result(ttrb_pkg::op_e op,
                                                        logic [ttrb_pkg::TickW-1:0] tick,
                                                        logic [ttrb_pkg::PayloadPortW-1:0] pay);
    ring_result_t    r;
    logic [PtrW-1:0] slot;
    r = '0;
    case (op)
      ttrb_pkg::OpRecord: begin
        ring_tick[wr_ptr] = tick;
        ring_pay[wr_ptr]  = pay;
        wr_ptr            = wr_ptr + 1'b1;
        if (held < Depth) held = held + 1'b1;
      end
      ttrb_pkg::OpLookup: begin
        for (int unsigned back = 1; back <= held; back++) begin
          slot = wr_ptr - back[PtrW-1:0];
          if (ring_tick[slot] == tick) begin
            r.found       = 1'b1;
            r.payload_out = ring_pay[slot];
            break;
          end
        end
      end
      ttrb_pkg::OpDiscard: begin
        // oldest held entry sits held slots behind the write pointer
        while (held > 0) begin
          slot = wr_ptr - held[PtrW-1:0];
          if (ring_tick[slot] < tick) held = held - 1'b1;
          else break;
        end
      end
      default: begin
        wr_ptr = '0;
        held   = '0;
      end
    endcase
    r.held_count = held;
    return r;
  endfunction

  task automatic add_row(ttrb_pkg::op_e op, logic [ttrb_pkg::TickW-1:0] tick,
                         logic [ttrb_pkg::PayloadPortW-1:0] pay,
                         bit typed, logic found, logic [ttrb_pkg::PayloadPortW-1:0] pout,
                         logic [CntW-1:0] cnt);
    stim_row_t row;
    row.op    = op;
    row.tick  = tick;
    row.pay   = pay;
    row.typed = typed;
    row.res   = '{found, pout, cnt};
    directed_rows.push_back(row);
  endtask

  task automatic send_word(ttrb_pkg::op_e op, logic [ttrb_pkg::TickW-1:0] tick,
                           logic [ttrb_pkg::PayloadPortW-1:0] pay,
                           bit typed = 1'b0, ring_result_t typed_res = '0);
    ring_result_t res;
    int unsigned  gap;
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.tick      <= tick;
    in_if.payload   <= pay;
    offering = 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    res = predict_ring_result(op, tick, pay);
    pending_results.push_back(typed ? typed_res : res);
    words_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(1, 10);
      in_if.valid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    if (offering) begin
      in_if.valid <= 1'b0;
      offering = 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h", $time, name, exp_v, act_v);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, %s found=%0b payload=0x%08h count=%0d",
                 $time, "actual", out_if.found, out_if.payload_out, out_if.held_count);
        mismatch_cnt++;
      end else begin
        exp_word = pending_results.pop_front();
        check_field("found", 32'(exp_word.found), 32'(out_if.found));
        check_field("payload_out", exp_word.payload_out, out_if.payload_out);
        check_field("held_count", 32'(exp_word.held_count), 32'(out_if.held_count));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog, no word moved for %0d cycles", $time, idle_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // result side: stall patterns, plus two long hold-offs that back the block up
  initial begin : result_side
    int unsigned mode;
    int unsigned span;
    int unsigned phase;
    int unsigned holdoffs;
    holdoffs = 0;
    phase    = 0;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (holdoffs < 2 && results_seen >= 150 + 650 * holdoffs) begin
        holdoffs++;
        out_if.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 9);
        span = $urandom_range(20, 150);
        repeat (span) begin
          phase++;
          case (mode) inside
            [0:3]:   out_if.ready <= 1'b1;
            [4:6]:   out_if.ready <= ($urandom_range(0, 3) != 0);
            [7:8]:   out_if.ready <= 1'($urandom_range(0, 1));
            default: out_if.ready <= (phase % 5 != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned                kind;
    int unsigned                n;
    int unsigned                sel;
    bit                         paused;
    logic [ttrb_pkg::TickW-1:0] game_tick;
    paused    = 1'b0;
    game_tick = '0;
    in_if.valid     <= 1'b0;
    in_if.operation <= ttrb_pkg::OpRecord;
    in_if.tick      <= '0;
    in_if.payload   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(ttrb_pkg::OpLookup,  32'h0,         32'h0,         1, 0, 32'h0,         0);
    add_row(ttrb_pkg::OpDiscard, 32'hFFFF_FFFF, 32'h0,         1, 0, 32'h0,         0);
    add_row(ttrb_pkg::OpClear,   32'h0,         32'hFFFF_FFFF, 1, 0, 32'h0,         0);
    add_row(ttrb_pkg::OpRecord,  32'h0,         32'hFFFF_FFFF, 1, 0, 32'h0,         1);
    add_row(ttrb_pkg::OpRecord,  32'hFFFF_FFFF, 32'h0,         1, 0, 32'h0,         2);
    add_row(ttrb_pkg::OpLookup,  32'hFFFF_FFFF, 32'h0,         1, 1, 32'h0,         2);
    add_row(ttrb_pkg::OpLookup,  32'h0,         32'h0,         1, 1, 32'hFFFF_FFFF, 2);
    add_row(ttrb_pkg::OpRecord,  32'd5,         32'hA5A5_A5A5, 0, 0, 32'h0,         0);
    add_row(ttrb_pkg::OpRecord,  32'd5,         32'h5A5A_5A5A, 0, 0, 32'h0,         0);
    add_row(ttrb_pkg::OpLookup,  32'd5,         32'h0,         0, 0, 32'h0,         0);
    add_row(ttrb_pkg::OpLookup,  32'd7,         32'h0,         0, 0, 32'h0,         0);
    add_row(ttrb_pkg::OpDiscard, 32'd1,         32'h0,         0, 0, 32'h0,         0);
    add_row(ttrb_pkg::OpDiscard, 32'd6,         32'h0,         0, 0, 32'h0,         0);
    add_row(ttrb_pkg::OpDiscard, 32'd0,         32'h0,         0, 0, 32'h0,         0);
    add_row(ttrb_pkg::OpRecord,  32'd3,         32'h1234_5678, 0, 0, 32'h0,         0);
    add_row(ttrb_pkg::OpDiscard, 32'hFFFF_FFFF, 32'h0,         0, 0, 32'h0,         0);
    add_row(ttrb_pkg::OpClear,   32'h0,         32'h0,         1, 0, 32'h0,         0);
    add_row(ttrb_pkg::OpLookup,  32'd5,         32'h0,         1, 0, 32'h0,         0);
    add_row(ttrb_pkg::OpDiscard, 32'hFFFF_FFFF, 32'h0,         1, 0, 32'h0,         0);
    add_row(ttrb_pkg::OpRecord,  32'd1,         32'h0,         1, 0, 32'h0,         1);
    add_row(ttrb_pkg::OpDiscard, 32'd2,         32'h0,         1, 0, 32'h0,         0);
    add_row(ttrb_pkg::OpLookup,  32'd1,         32'h0,         1, 0, 32'h0,         0);
    foreach (directed_rows[i])
      send_word(directed_rows[i].op, directed_rows[i].tick, directed_rows[i].pay,
                directed_rows[i].typed, directed_rows[i].res);
    drain_results();

    words_sent = 0;
    while (words_sent < RandWords) begin
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        n = $urandom_range(5, 20);
        repeat (n)
          send_word(ttrb_pkg::op_e'($urandom_range(ttrb_pkg::OpRecord, ttrb_pkg::OpClear)),
                    $urandom, $urandom);
      end else begin
        if ($urandom_range(0, 3) == 0) send_word(ttrb_pkg::OpClear, $urandom, $urandom);
        case ($urandom_range(0, 3))
          0: game_tick = $urandom;
          1: game_tick = 32'hFFFF_FFFF - $urandom_range(0, 100);
          2: game_tick = $urandom_range(0, 100);
          default: ;
        endcase
        // long runs wrap the ring and overwrite the oldest entries
        n = (kind < 35) ? $urandom_range(65, 110) : $urandom_range(10, 60);
        repeat (n) begin
          sel = $urandom_range(0, 99);
          if (sel < 55) begin
            send_word(ttrb_pkg::OpRecord, game_tick, $urandom);
            if (sel < 50) game_tick = game_tick + 1;
          end else if (sel < 85) begin
            send_word(ttrb_pkg::OpLookup, game_tick - $urandom_range(1, 80), $urandom);
          end else begin
            send_word(ttrb_pkg::OpDiscard, game_tick - $urandom_range(0, 70), $urandom);
          end
        end
      end
      if (!paused && words_sent > RandWords / 2) begin
        paused = 1'b1;
        drain_results();
      end
    end
    drain_results();
    repeat (TailCycles) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
